[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant violated");

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

[rtl/seg_pkg.sv]
`default_nettype none

package seg_pkg;

    localparam int LEVEL_FRACTION_BITS = 23;
    localparam int LEVEL_W             = LEVEL_FRACTION_BITS + 1;
    localparam int COEFF_BITS          = 24;
    localparam int CFG_W               = 24;
    localparam int OUT_LEVEL_W         = 24;
    localparam int CFG_INDEX_W         = 3;
    localparam int SUM_W               = ((LEVEL_W > CFG_W) ? LEVEL_W : CFG_W) + 1;
    localparam int PROD_W              = LEVEL_W + COEFF_BITS;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRACTION_BITS{1'b0}}};

    // Thresholds are 0.0005 and 0.0001 of full scale, rounded up.
    localparam longint unsigned DECAY_THR_FULL =
        ((64'd5 << LEVEL_FRACTION_BITS) + 64'd9999) / 64'd10000;
    localparam longint unsigned RELEASE_THR_FULL =
        ((64'd1 << LEVEL_FRACTION_BITS) + 64'd9999) / 64'd10000;
    localparam logic [LEVEL_W-1:0] DECAY_THRESHOLD   = LEVEL_W'(DECAY_THR_FULL);
    localparam logic [LEVEL_W-1:0] RELEASE_THRESHOLD = LEVEL_W'(RELEASE_THR_FULL);

    localparam logic [CFG_W-1:0] SUSTAIN_RESET = CFG_W'(LEVEL_ONE);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ATTACK_STEP    = 3'd0,
        CFG_DECAY_COEFF    = 3'd1,
        CFG_SUSTAIN_LEVEL  = 3'd2,
        CFG_RELEASE_COEFF  = 3'd3,
        CFG_IGNORE_RELEASE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] attack_step;
        logic [CFG_W-1:0] decay_coeff;
        logic [CFG_W-1:0] sustain_level;
        logic [CFG_W-1:0] release_coeff;
        logic             ignore_release;
    } t_cfg;

    typedef struct packed {
        t_stage             stage;
        logic [LEVEL_W-1:0] level;
        logic               hold;
    } t_env_state;

    typedef struct packed {
        logic [OUT_LEVEL_W-1:0] level;
        logic                   active;
        logic                   finished;
    } t_result;

endpackage

`default_nettype wire

[rtl/seg_step.sv]
`default_nettype none

module seg_step (
    input  seg_pkg::t_env_state i_state,
    input  seg_pkg::t_cfg       i_cfg,
    input  logic [1:0]          i_op,
    input  logic                i_trig,
    output seg_pkg::t_env_state o_state,
    output seg_pkg::t_result    o_result
);
    import seg_pkg::*;

    t_stage               cur_stage;
    t_stage               after_peak;
    logic [LEVEL_W-1:0]   target;
    logic [SUM_W-1:0]     attack_sum;
    logic [LEVEL_W-1:0]   decay_diff;
    logic [LEVEL_W-1:0]   mul_a;
    logic [COEFF_BITS-1:0] mul_c;
    logic [PROD_W-1:0]    product;
    logic [LEVEL_W-1:0]   scaled;
    t_env_state           n_state;
    logic [LEVEL_W-1:0]   reported;
    logic                 fin;

    // Stage codes above release cannot occur but are treated as idle.
    assign cur_stage  = (i_state.stage > ST_RELEASE) ? ST_IDLE : i_state.stage;
    assign after_peak = (i_cfg.decay_coeff != '0) ? ST_DECAY : ST_SUSTAIN;

    assign target = (SUM_W'(i_cfg.sustain_level) > SUM_W'(LEVEL_ONE)) ?
                    LEVEL_ONE : LEVEL_W'(i_cfg.sustain_level);

    assign attack_sum = SUM_W'(i_state.level) + SUM_W'(i_cfg.attack_step);

    // One multiplier serves both decay (distance to target) and release (level).
    assign decay_diff = (i_state.level > target) ? (i_state.level - target) : '0;
    assign mul_a      = (cur_stage == ST_DECAY) ? decay_diff : i_state.level;
    assign mul_c      = (cur_stage == ST_DECAY) ? i_cfg.decay_coeff : i_cfg.release_coeff;
    assign product    = PROD_W'(mul_a) * PROD_W'(mul_c);
    assign scaled     = product[PROD_W-1:COEFF_BITS];

    always_comb begin
        n_state       = i_state;
        n_state.stage = cur_stage;
        fin           = 1'b0;
        reported      = i_state.level;
        unique case (i_op)
            OP_TICK: begin
                unique case (cur_stage)
                    ST_ATTACK: begin
                        if (attack_sum >= SUM_W'(LEVEL_ONE)) begin
                            n_state.level = LEVEL_ONE;
                            n_state.stage = after_peak;
                        end else begin
                            n_state.level = LEVEL_W'(attack_sum);
                        end
                    end
                    ST_DECAY: begin
                        if (scaled < DECAY_THRESHOLD) begin
                            n_state.level = target;
                            n_state.stage = ST_SUSTAIN;
                        end else begin
                            n_state.level = target + scaled;
                        end
                    end
                    ST_RELEASE: begin
                        if (scaled < RELEASE_THRESHOLD) begin
                            n_state.level = '0;
                            n_state.stage = ST_IDLE;
                            fin           = 1'b1;
                        end else begin
                            n_state.level = scaled;
                        end
                    end
                    default: ;
                endcase
            end
            OP_START: begin
                n_state.hold = i_trig;
                if (i_cfg.attack_step != '0) begin
                    n_state.level = '0;
                    n_state.stage = ST_ATTACK;
                end else begin
                    n_state.level = LEVEL_ONE;
                    n_state.stage = after_peak;
                end
                if (i_trig) begin
                    n_state.stage = ST_SUSTAIN;
                end
                reported = n_state.level;
            end
            OP_RELEASE: begin
                if (cur_stage != ST_IDLE && !i_state.hold && !i_cfg.ignore_release) begin
                    n_state.stage = ST_RELEASE;
                end
            end
            default: ;
        endcase
    end

    assign o_state           = n_state;
    assign o_result.level    = OUT_LEVEL_W'(reported);
    assign o_result.active   = (n_state.stage != ST_IDLE);
    assign o_result.finished = fin;

endmodule

`default_nettype wire

[rtl/sampler_envelope_generator.sv]
// Envelope generator for one sampler voice (attack, decay, sustain, release).
// Input stream: one item per operation. tuser carries the op code (tick one
// frame, start note, release note); tdata bit 0 carries the release-trigger
// flag used by a start. Output stream: one result item per input item with
// the level, the active flag and the release-finished flag.
// Configuration channel: register index and 24-bit data, ready whenever reset
// is released; write only while no items are in flight.
// An accepted item is held in the input register; its result is then held in
// the output register. Throughput is one item per cycle while the receiver
// accepts results; the envelope update (one shared 24x24 multiply, an add and a
// compare) finishes in the cycle the item leaves the input register.
// When the receiver stalls, the result is held in the output register, the
// input register takes one more item, and then s_axis_tready goes low.
// Reset (synchronous, active low) puts the voice in idle with level zero,
// clears the valid flags of both registers and loads the register defaults (sustain at 1.0).
// Both ready outputs stay low while reset is held.
`default_nettype none
`include "assert_macros.svh"

module sampler_envelope_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [0] release_trigger
    input  logic [1:0]                      s_axis_tuser,   // [1:0] op
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,   // [23:0] level, [24] active,
                                                            // [25] finished
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [seg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [seg_pkg::CFG_W-1:0]       i_cfg_data
);
    import seg_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic       r_in_trig;
    logic       r_out_valid;
    t_result    r_out;
    t_env_state r_state;
    t_env_state step_state;
    t_result    step_result;
    logic       in_accept;
    logic       adv;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step    <= '0;
            r_cfg.decay_coeff    <= '0;
            r_cfg.sustain_level  <= SUSTAIN_RESET;
            r_cfg.release_coeff  <= '0;
            r_cfg.ignore_release <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATTACK_STEP:    r_cfg.attack_step    <= i_cfg_data;
                CFG_DECAY_COEFF:    r_cfg.decay_coeff    <= i_cfg_data;
                CFG_SUSTAIN_LEVEL:  r_cfg.sustain_level  <= i_cfg_data;
                CFG_RELEASE_COEFF:  r_cfg.release_coeff  <= i_cfg_data;
                CFG_IGNORE_RELEASE: r_cfg.ignore_release <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The item in the input register moves on whenever the output register is free.
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || adv);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    seg_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_op     (r_in_op),
        .i_trig   (r_in_trig),
        .o_state  (step_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.stage <= ST_IDLE;
            r_state.level <= '0;
            r_state.hold  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= step_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= s_axis_tuser;
            r_in_trig <= s_axis_tdata[0];
        end
        if (adv) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.finished, r_out.active, r_out.level};

    `ASSERT_ALWAYS(a_level_in_range, i_clk, i_rst_n, r_state.level <= LEVEL_ONE)
    `ASSERT_IMPLY(a_idle_level_zero, i_clk, i_rst_n, r_state.stage == ST_IDLE,
                  r_state.level == '0)
    `ASSERT_IMPLY(a_hold_blocks_release, i_clk, i_rst_n, r_state.hold,
                  r_state.stage != ST_RELEASE)
    `ASSERT_IMPLY(a_finished_not_active, i_clk, i_rst_n, r_out_valid && r_out.finished,
                  !r_out.active)
    `ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, adv, r_out_valid)

endmodule

`default_nettype wire
